### design/dnms_pkg.sv
// Shared types and constants of the detection decode and class NMS block.
// No dependencies; every other design file imports this package.
package dnms_pkg;

    localparam int MAX_CANDIDATES = 64;
    localparam int MAX_CLASSES    = 80;
    localparam int CAND_AW        = $clog2(MAX_CANDIDATES);
    localparam int CAND_CW        = $clog2(MAX_CANDIDATES + 1);
    localparam int CLS_CNT_W      = $clog2(MAX_CLASSES + 1);
    localparam int CLS_W          = 8;
    localparam int JOBQ_DEPTH     = 4;
    localparam int JOBQ_AW        = $clog2(JOBQ_DEPTH);
    localparam logic [11:0] EDGE_MAX = 12'hFFF;
    // divider: dividend up to 18b x 12b, divisor up to 32 * 12b
    localparam int DVD_W  = 30;
    localparam int DSOR_W = 17;
    localparam int DCNT_W = $clog2(DVD_W);

    typedef enum logic [2:0] {
        CFG_CONF_THR = 3'd0,
        CFG_IOU_THR  = 3'd1,
        CFG_SRC_W    = 3'd2,
        CFG_SRC_H    = 3'd3,
        CFG_DST_W    = 3'd4,
        CFG_DST_H    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] conf_thr;
        logic [15:0] iou_thr;
        logic [11:0] src_w;
        logic [11:0] src_h;
        logic [11:0] dst_w;
        logic [11:0] dst_h;
    } t_cfg;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] bw;
        logic [15:0] bh;
        logic [15:0] score;
        logic        last_class;
        logic        last_anchor;
    } t_item;

    typedef struct packed {
        logic [15:0]      cx;
        logic [15:0]      cy;
        logic [15:0]      bw;
        logic [15:0]      bh;
        logic [15:0]      score;
        logic [CLS_W-1:0] cls;
        logic             cand;
        logic             frame_end;
    } t_job;

    typedef struct packed {
        logic [11:0]      left;
        logic [11:0]      top;
        logic [11:0]      right;
        logic [11:0]      bottom;
        logic [CLS_W-1:0] class_index;
        logic [15:0]      best_score;
        logic             none_found;
        logic             overflowed;
        logic             last_result;
    } t_result;

    typedef enum logic [2:0] {
        D_UW = 3'd0,
        D_UH = 3'd1,
        D_L  = 3'd2,
        D_T  = 3'd3,
        D_R  = 3'd4,
        D_B  = 3'd5
    } t_dstep;

    typedef enum logic [4:0] {
        B_IDLE, B_RATIO, B_NUM, B_PREP, B_DIV, B_POST, B_STORE, B_CHK,
        B_SSTART, B_SRD, B_SEV, B_SDONE, B_CLD, B_EMIT,
        B_PRD, B_PEV, B_IOU1, B_IOU2, B_IOU3, B_FIN
    } t_bstate;

endpackage

### design/detection_decode_and_class_nms.sv
// Top level of the detection decode and per-class NMS block.
// Depends on dnms_pkg, dnms_front, dnms_job_queue and dnms_back.
//
// Items (one class score of one anchor, with the anchor's box) are taken one
// per cycle while full is low. The front end keeps the argmax over an
// anchor's scores and hands a job to a four-deep queue when an anchor beats
// the confidence threshold or the frame ends; full rises only while that
// queue is full.
// The back end works one job at a time: a candidate costs six serial
// divisions plus setup, so a burst of passing anchors can stall the input.
// At the frame end greedy NMS runs over the N stored candidates: each
// selection round reads all N entries and each kept box runs a suppression
// scan over all N entries with an IoU check per same-class pair. Results
// come out through a two-entry queue (empty/pop); the last result of a frame
// carries last_result, and an empty frame gives one result with none_found
// set. Candidates past 64 are dropped and every result of that frame shows
// overflowed. Tables need no clearing pass.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken at once
// and must only happen while the block is idle; a zero size reads as one.
module detection_decode_and_class_nms (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_center_x,
    input  logic [15:0] i_center_y,
    input  logic [15:0] i_box_width,
    input  logic [15:0] i_box_height,
    input  logic [15:0] i_class_score,
    input  logic        i_last_class,
    input  logic        i_last_anchor,
    // result transactions
    output logic        empty,
    input  logic        pop,
    output logic [11:0] o_left,
    output logic [11:0] o_top,
    output logic [11:0] o_right,
    output logic [11:0] o_bottom,
    output logic [7:0]  o_class_index,
    output logic [15:0] o_best_score,
    output logic        o_none_found,
    output logic        o_overflowed,
    output logic        o_last_result,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import dnms_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_job    fe_job, jq_job;
    logic    fe_job_push, jq_full, jq_empty, jq_pop;
    t_result result;

    // register file; writes outside the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.conf_thr <= 16'd16384;
            r_cfg.iou_thr  <= 16'd29491;
            r_cfg.src_w    <= 12'd640;
            r_cfg.src_h    <= 12'd480;
            r_cfg.dst_w    <= 12'd640;
            r_cfg.dst_h    <= 12'd640;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CONF_THR: r_cfg.conf_thr <= i_cfg_data;
                CFG_IOU_THR:  r_cfg.iou_thr  <= i_cfg_data;
                CFG_SRC_W:    r_cfg.src_w    <= i_cfg_data[11:0];
                CFG_SRC_H:    r_cfg.src_h    <= i_cfg_data[11:0];
                CFG_DST_W:    r_cfg.dst_w    <= i_cfg_data[11:0];
                CFG_DST_H:    r_cfg.dst_h    <= i_cfg_data[11:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    assign item.cx          = i_center_x;
    assign item.cy          = i_center_y;
    assign item.bw          = i_box_width;
    assign item.bh          = i_box_height;
    assign item.score       = i_class_score;
    assign item.last_class  = i_last_class;
    assign item.last_anchor = i_last_anchor;

    dnms_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (item),
        .i_conf_thr (r_cfg.conf_thr),
        .i_jq_full  (jq_full),
        .o_full     (full),
        .o_job_push (fe_job_push),
        .o_job      (fe_job)
    );

    dnms_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_job_push),
        .i_job   (fe_job),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_job   (jq_job),
        .o_empty (jq_empty)
    );

    dnms_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_jq_empty (jq_empty),
        .i_jq_job   (jq_job),
        .o_jq_pop   (jq_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (result)
    );

    assign o_left        = result.left;
    assign o_top         = result.top;
    assign o_right       = result.right;
    assign o_bottom      = result.bottom;
    assign o_class_index = result.class_index;
    assign o_best_score  = result.best_score;
    assign o_none_found  = result.none_found;
    assign o_overflowed  = result.overflowed;
    assign o_last_result = result.last_result;

endmodule

### design/dnms_front.sv
// Front end: running first-wins argmax over an anchor's class scores.
// Depends on dnms_pkg; issues one job per candidate and per frame end.
module dnms_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dnms_pkg::t_item   i_item,
    input  logic [15:0]       i_conf_thr,
    input  logic              i_jq_full,
    output logic              o_full,
    output logic              o_job_push,
    output dnms_pkg::t_job    o_job
);
    import dnms_pkg::*;

    logic [15:0]          r_best_score, n_best_score;
    logic                 r_best_valid, n_best_valid;
    logic [CLS_W-1:0]     r_best_class, n_best_class;
    logic [CLS_CNT_W-1:0] r_class_cnt, n_class_cnt;

    logic                 accept;
    logic                 anchor_end;
    logic [15:0]          b_score;
    logic                 b_valid;
    logic [CLS_W-1:0]     b_class;

    assign o_full = i_jq_full;
    assign accept = i_push && !i_jq_full;
    assign anchor_end = i_item.last_class || i_item.last_anchor;

    always_comb begin
        b_score     = r_best_score;
        b_valid     = r_best_valid;
        b_class     = r_best_class;
        n_class_cnt = r_class_cnt;
        if (r_class_cnt < CLS_CNT_W'(MAX_CLASSES)) begin
            if (!r_best_valid || i_item.score > r_best_score) begin
                b_score = i_item.score;
                b_class = CLS_W'(r_class_cnt);
                b_valid = 1'b1;
            end
            n_class_cnt = r_class_cnt + 1'b1;
        end
        n_best_score = b_score;
        n_best_valid = b_valid;
        n_best_class = b_class;
        o_job.cx        = i_item.cx;
        o_job.cy        = i_item.cy;
        o_job.bw        = i_item.bw;
        o_job.bh        = i_item.bh;
        o_job.score     = b_score;
        o_job.cls       = b_class;
        o_job.cand      = anchor_end && b_valid && (b_score > i_conf_thr);
        o_job.frame_end = i_item.last_anchor;
        o_job_push      = accept && (o_job.cand || i_item.last_anchor);
        if (anchor_end) begin
            n_best_score = '0;
            n_best_valid = 1'b0;
            n_best_class = '0;
            n_class_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_valid <= 1'b0;
            r_best_class <= '0;
            r_class_cnt  <= '0;
        end else if (accept) begin
            r_best_score <= n_best_score;
            r_best_valid <= n_best_valid;
            r_best_class <= n_best_class;
            r_class_cnt  <= n_class_cnt;
        end
    end

endmodule

### design/dnms_job_queue.sv
// Short job queue between the front end and the back end.
// Depends on dnms_pkg for the job type and depth.
module dnms_job_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dnms_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output dnms_pkg::t_job  o_job,
    output logic            o_empty
);
    import dnms_pkg::*;

    t_job               r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] r_wp, r_rp;
    logic [JOBQ_AW:0]   r_cnt;
    logic               wr, rd;

    assign o_full  = (r_cnt == (JOBQ_AW+1)'(JOBQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (JOBQ_AW+1)'(wr) - (JOBQ_AW+1)'(rd);
        end
    end

endmodule

### design/dnms_back.sv
// Back end: letterbox undo with a serial divider, candidate tables, greedy NMS
// and a two-entry result queue. Depends on dnms_pkg.
module dnms_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dnms_pkg::t_cfg    i_cfg,
    input  logic              i_jq_empty,
    input  dnms_pkg::t_job    i_jq_job,
    output logic              o_jq_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output dnms_pkg::t_result o_result
);
    import dnms_pkg::*;

    t_bstate r_state, n_state;

    t_job                r_job, n_job;
    logic [11:0]         r_num, n_num, r_den, n_den;
    logic [23:0]         r_p1, n_p1, r_p2, n_p2;
    logic [11:0]         r_uw, n_uw, r_uh, n_uh;
    t_dstep              r_step, n_step;
    logic [DSOR_W-1:0]   r_dsor, n_dsor;
    logic [DSOR_W:0]     r_rem, n_rem;
    logic [DVD_W-1:0]    r_quo, n_quo;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic [11:0]         r_l, n_l, r_t, n_t, r_r, n_r, r_b, n_b;
    logic [CAND_CW-1:0]  r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [MAX_CANDIDATES-1:0] r_done, n_done, r_supp, n_supp;
    logic [CAND_CW-1:0]  r_idx, n_idx;
    logic                r_found, n_found;
    logic [CAND_AW-1:0]  r_best_idx, n_best_idx;
    logic [15:0]         r_best_score, n_best_score;
    logic [47:0]         r_cbox, n_cbox, r_dbox, n_dbox;
    logic [23:0]         r_ccs, n_ccs;
    logic [23:0]         r_inter, n_inter, r_a1, n_a1, r_a2, n_a2;
    logic [24:0]         r_uni, n_uni;
    logic [40:0]         r_tu, n_tu;
    logic                r_pend_v, n_pend_v;
    t_result             r_pend, n_pend;

    // candidate tables
    logic [47:0]        m_box [MAX_CANDIDATES];
    logic [23:0]        m_cs  [MAX_CANDIDATES];
    logic [47:0]        r_box_q;
    logic [23:0]        r_cs_q;
    logic               mem_we;
    logic [CAND_AW-1:0] rd_addr;

    // result queue
    t_result r_oq [2];
    logic    r_oq_wp, r_oq_rp;
    logic [1:0] r_oq_cnt;
    logic    oq_full, oq_push, oq_pop;
    t_result oq_din;

    // effective sizes: zero reads as one
    logic [11:0] sw, sh, dw, dh;
    assign sw = (i_cfg.src_w == '0) ? 12'd1 : i_cfg.src_w;
    assign sh = (i_cfg.src_h == '0) ? 12'd1 : i_cfg.src_h;
    assign dw = (i_cfg.dst_w == '0) ? 12'd1 : i_cfg.dst_w;
    assign dh = (i_cfg.dst_h == '0) ? 12'd1 : i_cfg.dst_h;

    // edge operand selection
    logic               horiz, plus;
    logic [15:0]        e_c, e_s, e_pad;
    logic signed [19:0] e_a;
    logic [23:0]        u_prod;
    logic [DVD_W-1:0]   e_dvd;
    assign horiz = (r_step == D_L) || (r_step == D_R);
    assign plus  = (r_step == D_R) || (r_step == D_B);
    assign e_c   = horiz ? r_job.cx : r_job.cy;
    assign e_s   = horiz ? r_job.bw : r_job.bh;
    assign e_pad = horiz ? {dw - r_uw, 4'b0} : {dh - r_uh, 4'b0};
    assign e_a   = plus ? $signed({3'b0, e_c, 1'b0}) + $signed({4'b0, e_s})
                            - $signed({4'b0, e_pad})
                        : $signed({3'b0, e_c, 1'b0}) - $signed({4'b0, e_s})
                            - $signed({4'b0, e_pad});
    assign e_dvd = (e_a > 20'sd0) ? DVD_W'(e_a[17:0]) * DVD_W'(r_den) : '0;
    assign u_prod = ((r_step == D_UW) ? sw : sh) * r_num;

    // one restoring division step
    logic [DSOR_W:0]   d_sh;
    logic [DSOR_W+1:0] d_trial;
    assign d_sh    = {r_rem[DSOR_W-1:0], r_quo[DVD_W-1]};
    assign d_trial = {1'b0, d_sh} - {2'b0, r_dsor};

    logic [11:0] q_clamp;
    assign q_clamp = (|r_quo[DVD_W-1:12]) ? EDGE_MAX : r_quo[11:0];

    // IoU operands
    logic [11:0] ix1, iy1, ix2, iy2, iw, ih;
    assign ix1 = (r_cbox[11:0]  > r_dbox[11:0])  ? r_cbox[11:0]  : r_dbox[11:0];
    assign iy1 = (r_cbox[23:12] > r_dbox[23:12]) ? r_cbox[23:12] : r_dbox[23:12];
    assign ix2 = (r_cbox[35:24] < r_dbox[35:24]) ? r_cbox[35:24] : r_dbox[35:24];
    assign iy2 = (r_cbox[47:36] < r_dbox[47:36]) ? r_cbox[47:36] : r_dbox[47:36];
    assign iw  = (ix2 > ix1) ? ix2 - ix1 : '0;
    assign ih  = (iy2 > iy1) ? iy2 - iy1 : '0;

    logic scan_last;
    assign scan_last = ((r_idx + 1'b1) == r_count);

    always_comb begin
        n_state = r_state;
        n_job = r_job; n_num = r_num; n_den = r_den; n_p1 = r_p1; n_p2 = r_p2;
        n_uw = r_uw; n_uh = r_uh; n_step = r_step; n_dsor = r_dsor;
        n_rem = r_rem; n_quo = r_quo; n_dcnt = r_dcnt;
        n_l = r_l; n_t = r_t; n_r = r_r; n_b = r_b;
        n_count = r_count; n_ovf = r_ovf; n_done = r_done; n_supp = r_supp;
        n_idx = r_idx; n_found = r_found; n_best_idx = r_best_idx;
        n_best_score = r_best_score; n_cbox = r_cbox; n_dbox = r_dbox;
        n_ccs = r_ccs; n_inter = r_inter; n_a1 = r_a1; n_a2 = r_a2;
        n_uni = r_uni; n_tu = r_tu; n_pend_v = r_pend_v; n_pend = r_pend;
        o_jq_pop = 1'b0;
        mem_we   = 1'b0;
        rd_addr  = r_idx[CAND_AW-1:0];
        oq_push  = 1'b0;
        oq_din   = r_pend;
        unique case (r_state)
            B_IDLE: begin
                if (!i_jq_empty) begin
                    o_jq_pop = 1'b1;
                    n_job    = i_jq_job;
                    if (!i_jq_job.cand) begin
                        n_state = B_CHK;
                    end else if (r_count == CAND_CW'(MAX_CANDIDATES)) begin
                        n_ovf   = 1'b1;
                        n_state = B_CHK;
                    end else begin
                        n_state = B_RATIO;
                    end
                end
            end
            B_RATIO: begin
                n_p1    = dw * sh;
                n_p2    = dh * sw;
                n_state = B_NUM;
            end
            B_NUM: begin
                if (r_p1 <= r_p2) begin
                    n_num = dw; n_den = sw;
                end else begin
                    n_num = dh; n_den = sh;
                end
                n_step  = D_UW;
                n_state = B_PREP;
            end
            B_PREP: begin
                if (r_step == D_UW || r_step == D_UH) begin
                    n_quo  = DVD_W'({u_prod, 1'b0}) + DVD_W'(r_den);
                    n_dsor = DSOR_W'({r_den, 1'b0});
                end else begin
                    n_quo  = e_dvd;
                    n_dsor = {r_num, 5'b0};
                end
                n_rem   = '0;
                n_dcnt  = DCNT_W'(DVD_W - 1);
                n_state = B_DIV;
            end
            B_DIV: begin
                if (!d_trial[DSOR_W+1]) begin
                    n_rem = d_trial[DSOR_W:0];
                    n_quo = {r_quo[DVD_W-2:0], 1'b1};
                end else begin
                    n_rem = d_sh;
                    n_quo = {r_quo[DVD_W-2:0], 1'b0};
                end
                if (r_dcnt == '0) n_state = B_POST;
                else n_dcnt = r_dcnt - 1'b1;
            end
            B_POST: begin
                n_state = B_PREP;
                unique case (r_step)
                    D_UW: begin n_uw = r_quo[11:0]; n_step = D_UH; end
                    D_UH: begin n_uh = r_quo[11:0]; n_step = D_L;  end
                    D_L:  begin n_l  = q_clamp;     n_step = D_T;  end
                    D_T:  begin n_t  = q_clamp;     n_step = D_R;  end
                    D_R:  begin n_r  = q_clamp;     n_step = D_B;  end
                    D_B:  begin n_b  = q_clamp;     n_state = B_STORE; end
                    default: n_state = B_STORE;
                endcase
            end
            B_STORE: begin
                mem_we  = 1'b1;
                n_count = r_count + 1'b1;
                n_state = B_CHK;
            end
            B_CHK: begin
                n_state = r_job.frame_end ? B_SSTART : B_IDLE;
            end
            B_SSTART: begin
                n_idx   = '0;
                n_found = 1'b0;
                n_state = (r_count == '0) ? B_FIN : B_SRD;
            end
            B_SRD: begin
                n_state = B_SEV;
            end
            B_SEV: begin
                if (!r_done[r_idx[CAND_AW-1:0]] &&
                    (!r_found || r_cs_q[15:0] > r_best_score)) begin
                    n_found      = 1'b1;
                    n_best_idx   = r_idx[CAND_AW-1:0];
                    n_best_score = r_cs_q[15:0];
                end
                if (scan_last) begin
                    n_state = B_SDONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = B_SRD;
                end
            end
            B_SDONE: begin
                rd_addr = r_best_idx;
                if (!r_found) begin
                    n_state = B_FIN;
                end else begin
                    n_done[r_best_idx] = 1'b1;
                    n_state = r_supp[r_best_idx] ? B_SSTART : B_CLD;
                end
            end
            B_CLD: begin
                n_cbox  = r_box_q;
                n_ccs   = r_cs_q;
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (!(r_pend_v && oq_full)) begin
                    oq_push = r_pend_v;
                    n_pend.left        = r_cbox[11:0];
                    n_pend.top         = r_cbox[23:12];
                    n_pend.right       = r_cbox[35:24];
                    n_pend.bottom      = r_cbox[47:36];
                    n_pend.class_index = r_ccs[23:16];
                    n_pend.best_score  = r_ccs[15:0];
                    n_pend.none_found  = 1'b0;
                    n_pend.overflowed  = r_ovf;
                    n_pend.last_result = 1'b0;
                    n_pend_v = 1'b1;
                    n_idx    = '0;
                    n_state  = B_PRD;
                end
            end
            B_PRD: begin
                n_state = B_PEV;
            end
            B_PEV: begin
                n_dbox = r_box_q;
                if (!r_done[r_idx[CAND_AW-1:0]] && r_cs_q[23:16] == r_ccs[23:16]) begin
                    n_state = B_IOU1;
                end else if (scan_last) begin
                    n_state = B_SSTART;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = B_PRD;
                end
            end
            B_IOU1: begin
                n_inter = iw * ih;
                n_a1    = (r_cbox[35:24] - r_cbox[11:0]) * (r_cbox[47:36] - r_cbox[23:12]);
                n_a2    = (r_dbox[35:24] - r_dbox[11:0]) * (r_dbox[47:36] - r_dbox[23:12]);
                n_state = B_IOU2;
            end
            B_IOU2: begin
                n_uni   = {1'b0, r_a1} + {1'b0, r_a2} - {1'b0, r_inter};
                n_tu    = 41'(i_cfg.iou_thr)
                          * 41'({1'b0, r_a1} + {1'b0, r_a2} - {1'b0, r_inter});
                n_state = B_IOU3;
            end
            B_IOU3: begin
                // empty union: suppress only at a zero threshold
                if (r_uni == '0) begin
                    if (i_cfg.iou_thr == '0) n_supp[r_idx[CAND_AW-1:0]] = 1'b1;
                end else if (!({1'b0, r_inter, 16'b0} < r_tu)) begin
                    n_supp[r_idx[CAND_AW-1:0]] = 1'b1;
                end
                if (scan_last) begin
                    n_state = B_SSTART;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = B_PRD;
                end
            end
            B_FIN: begin
                if (!oq_full) begin
                    oq_push = 1'b1;
                    if (r_pend_v) begin
                        oq_din             = r_pend;
                        oq_din.last_result = 1'b1;
                    end else begin
                        oq_din             = '0;
                        oq_din.none_found  = 1'b1;
                        oq_din.overflowed  = r_ovf;
                        oq_din.last_result = 1'b1;
                    end
                    n_count  = '0;
                    n_ovf    = 1'b0;
                    n_done   = '0;
                    n_supp   = '0;
                    n_pend_v = 1'b0;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_done   <= '0;
            r_supp   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_done   <= n_done;
            r_supp   <= n_supp;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job; r_num <= n_num; r_den <= n_den; r_p1 <= n_p1; r_p2 <= n_p2;
        r_uw <= n_uw; r_uh <= n_uh; r_step <= n_step; r_dsor <= n_dsor;
        r_rem <= n_rem; r_quo <= n_quo; r_dcnt <= n_dcnt;
        r_l <= n_l; r_t <= n_t; r_r <= n_r; r_b <= n_b;
        r_idx <= n_idx; r_found <= n_found; r_best_idx <= n_best_idx;
        r_best_score <= n_best_score; r_cbox <= n_cbox; r_dbox <= n_dbox;
        r_ccs <= n_ccs; r_inter <= n_inter; r_a1 <= n_a1; r_a2 <= n_a2;
        r_uni <= n_uni; r_tu <= n_tu; r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_box[r_count[CAND_AW-1:0]] <= {r_b, r_r, r_t, r_l};
            m_cs[r_count[CAND_AW-1:0]]  <= {r_job.cls, r_job.score};
        end
        r_box_q <= m_box[rd_addr];
        r_cs_q  <= m_cs[rd_addr];
    end

    // result queue
    assign oq_full  = (r_oq_cnt == 2'd2);
    assign o_empty  = (r_oq_cnt == 2'd0);
    assign oq_pop   = i_pop && !o_empty;
    assign o_result = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (oq_push) r_oq[r_oq_wp] <= oq_din;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (oq_push) r_oq_wp <= ~r_oq_wp;
            if (oq_pop)  r_oq_rp <= ~r_oq_rp;
            r_oq_cnt <= r_oq_cnt + 2'(oq_push) - 2'(oq_pop);
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAND_CW'(MAX_CANDIDATES))
        else $error("candidate count beyond table size");
    a_oq_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_push |-> (!oq_full || oq_pop))
        else $error("result queue overrun");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_dsor != '0))
        else $error("division by zero");
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FIN && oq_full) |=> (r_state == B_FIN))
        else $error("frame closed while result queue full");

endmodule

### tb/dnms_checker.sv
`timescale 1ns / 1ps
// Result checker for detection_decode_and_class_nms: watches the register port and both queues.
// Depends on dnms_pkg; predicts kept boxes per frame and compares every popped result.
module dnms_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [15:0] i_center_x,
    input  logic [15:0] i_center_y,
    input  logic [15:0] i_box_width,
    input  logic [15:0] i_box_height,
    input  logic [15:0] i_class_score,
    input  logic        i_last_class,
    input  logic        i_last_anchor,
    input  logic        empty,
    input  logic        pop,
    input  logic [11:0] o_left,
    input  logic [11:0] o_top,
    input  logic [11:0] o_right,
    input  logic [11:0] o_bottom,
    input  logic [7:0]  o_class_index,
    input  logic [15:0] o_best_score,
    input  logic        o_none_found,
    input  logic        o_overflowed,
    input  logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_results_seen,
    output int          o_overflow_frames
);
    import dnms_pkg::*;

    logic [15:0] conf_thr = 16'd16384;
    logic [15:0] iou_thr  = 16'd29491;
    logic [11:0] src_w = 12'd640, src_h = 12'd480, dst_w = 12'd640, dst_h = 12'd640;

    logic [47:0] cand_box[MAX_CANDIDATES];
    logic [23:0] cand_cls_score[MAX_CANDIDATES];
    int          cand_cnt = 0;
    logic [15:0] best_score = '0;
    bit          best_valid = 0;
    logic [7:0]  best_cls = '0;
    int          cls_pos = 0;
    bit          ovf = 0;

    t_result     expected_boxes[$];

    assign o_waiting = expected_boxes.size();

    function automatic longint size_or_one(logic [11:0] v);
        return (v == 0) ? 1 : longint'(v);
    endfunction

    function automatic logic [11:0] unmap_edge(longint a32, longint num, longint den);
        longint q;
        if (a32 <= 0) return 12'd0;
        q = (a32 * den) / (32 * num);
        return (q > 4095) ? 12'hFFF : q[11:0];
    endfunction

    function automatic longint box_fld(logic [47:0] b, int k);
        return longint'(b[12*k +: 12]);
    endfunction

    function automatic bit too_close(logic [47:0] p, logic [47:0] q);
        longint ix1, iy1, ix2, iy2, iw, ih, inter, a1, a2, uni;
        ix1 = box_fld(p, 0) > box_fld(q, 0) ? box_fld(p, 0) : box_fld(q, 0);
        iy1 = box_fld(p, 1) > box_fld(q, 1) ? box_fld(p, 1) : box_fld(q, 1);
        ix2 = box_fld(p, 2) < box_fld(q, 2) ? box_fld(p, 2) : box_fld(q, 2);
        iy2 = box_fld(p, 3) < box_fld(q, 3) ? box_fld(p, 3) : box_fld(q, 3);
        iw = ix2 > ix1 ? ix2 - ix1 : 0;
        ih = iy2 > iy1 ? iy2 - iy1 : 0;
        inter = iw * ih;
        a1 = (box_fld(p, 2) - box_fld(p, 0)) * (box_fld(p, 3) - box_fld(p, 1));
        a2 = (box_fld(q, 2) - box_fld(q, 0)) * (box_fld(q, 3) - box_fld(q, 1));
        uni = a1 + a2 - inter;
        if (uni == 0) return iou_thr == 0;
        return !(inter * 65536 < longint'(iou_thr) * uni);
    endfunction

    // Letterbox undo of the anchor box, stored as a candidate if room is left.
    task automatic add_candidate();
        longint sw, sh, dw, dh, num, den, uw, uh, px, py, cx, cy, bw, bh;
        logic [11:0] l, t, r, b;
        sw = size_or_one(src_w); sh = size_or_one(src_h);
        dw = size_or_one(dst_w); dh = size_or_one(dst_h);
        if (dw * sh <= dh * sw) begin
            num = dw; den = sw;
        end else begin
            num = dh; den = sh;
        end
        uw = (2 * sw * num + den) / (2 * den);
        uh = (2 * sh * num + den) / (2 * den);
        px = 16 * (dw - uw);
        py = 16 * (dh - uh);
        cx = i_center_x; cy = i_center_y; bw = i_box_width; bh = i_box_height;
        l = unmap_edge(2 * cx - bw - px, num, den);
        t = unmap_edge(2 * cy - bh - py, num, den);
        r = unmap_edge(2 * cx + bw - px, num, den);
        b = unmap_edge(2 * cy + bh - py, num, den);
        if (cand_cnt >= MAX_CANDIDATES) begin
            ovf = 1;
            return;
        end
        cand_box[cand_cnt] = {b, r, t, l};
        cand_cls_score[cand_cnt] = {best_cls, best_score};
        cand_cnt++;
    endtask

    // Greedy per-class NMS in descending score order, stable on ties.
    task automatic run_frame_nms();
        int order[MAX_CANDIDATES];
        logic [63:0] supp;
        int i, j, c, d, n_out;
        t_result res;
        supp = '0;
        n_out = 0;
        for (i = 0; i < cand_cnt; i++) begin
            j = i;
            while (j > 0 && cand_cls_score[order[j-1]][15:0] < cand_cls_score[i][15:0]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i < cand_cnt; i++) begin
            c = order[i];
            if (supp[c]) continue;
            for (j = i + 1; j < cand_cnt; j++) begin
                d = order[j];
                if (cand_cls_score[d][23:16] != cand_cls_score[c][23:16]) continue;
                if (too_close(cand_box[c], cand_box[d])) supp[d] = 1'b1;
            end
            res = '0;
            res.left        = cand_box[c][11:0];
            res.top         = cand_box[c][23:12];
            res.right       = cand_box[c][35:24];
            res.bottom      = cand_box[c][47:36];
            res.class_index = cand_cls_score[c][23:16];
            res.best_score  = cand_cls_score[c][15:0];
            res.overflowed  = ovf;
            expected_boxes.insert(expected_boxes.size(), res);
            n_out++;
        end
        if (n_out == 0) begin
            res = '0;
            res.none_found = 1'b1;
            res.overflowed = ovf;
            expected_boxes.insert(expected_boxes.size(), res);
        end
        res = expected_boxes.pop_back();
        res.last_result = 1'b1;
        expected_boxes.insert(expected_boxes.size(), res);
        if (ovf) o_overflow_frames++;
        cand_cnt = 0;
        ovf = 0;
    endtask

    task automatic take_score_item();
        if (cls_pos < MAX_CLASSES) begin
            if (!best_valid || i_class_score > best_score) begin
                best_score = i_class_score;
                best_cls   = cls_pos[7:0];
                best_valid = 1;
            end
            cls_pos++;
        end
        if (i_last_class || i_last_anchor) begin
            if (best_valid && best_score > conf_thr) add_candidate();
            best_score = '0;
            best_valid = 0;
            best_cls   = '0;
            cls_pos    = 0;
        end
        if (i_last_anchor) run_frame_nms();
    endtask

    function automatic bit field_ok(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            return 0;
        end
        return 1;
    endfunction

    task automatic check_result();
        t_result e;
        bit ok;
        o_results_seen++;
        if (expected_boxes.size() == 0) begin
            $error("result transaction with nothing expected");
            o_fail_count++;
            return;
        end
        e = expected_boxes.pop_front();
        ok = 1;
        ok &= field_ok("left", e.left, o_left);
        ok &= field_ok("top", e.top, o_top);
        ok &= field_ok("right", e.right, o_right);
        ok &= field_ok("bottom", e.bottom, o_bottom);
        ok &= field_ok("class_index", e.class_index, o_class_index);
        ok &= field_ok("best_score", e.best_score, o_best_score);
        ok &= field_ok("none_found", e.none_found, o_none_found);
        ok &= field_ok("overflowed", e.overflowed, o_overflowed);
        ok &= field_ok("last_result", e.last_result, o_last_result);
        if (!ok) o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        o_overflow_frames = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_result();
            if (push && !full) take_score_item();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CONF_THR: conf_thr = i_cfg_data;
                    CFG_IOU_THR:  iou_thr  = i_cfg_data;
                    CFG_SRC_W:    src_w    = i_cfg_data[11:0];
                    CFG_SRC_H:    src_h    = i_cfg_data[11:0];
                    CFG_DST_W:    dst_w    = i_cfg_data[11:0];
                    CFG_DST_H:    dst_h    = i_cfg_data[11:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/detection_decode_and_class_nms_tb.sv
`timescale 1ns / 1ps
// Top of the detection_decode_and_class_nms testbench: clock, reset, stimulus and verdict.
// Depends on dnms_pkg, the block itself and dnms_checker.
module detection_decode_and_class_nms_tb;
    import dnms_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [15:0] i_center_x = 0, i_center_y = 0, i_box_width = 0, i_box_height = 0;
    logic [15:0] i_class_score = 0;
    logic        i_last_class = 0, i_last_anchor = 0;
    logic        empty;
    logic        pop = 0;
    logic [11:0] o_left, o_top, o_right, o_bottom;
    logic [7:0]  o_class_index;
    logic [15:0] o_best_score;
    logic        o_none_found, o_overflowed, o_last_result;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;

    int fail_count, waiting, results_seen, overflow_frames;

    // stimulus-side state
    int          items_sent = 0;
    int          frames_sent = 0;
    bit          tx_steady = 0;    // sender never idles
    bit          rx_steady = 0;    // receiver never idles
    bit          rx_hold_req = 0;  // receiver holds off for a long stretch
    logic [15:0] cur_conf = 16'd16384;
    logic [11:0] cur_dst_w = 12'd640, cur_dst_h = 12'd640;

    detection_decode_and_class_nms dut (.*);

    dnms_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_waiting(waiting),
        .o_results_seen(results_seen),
        .o_overflow_frames(overflow_frames)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: random pops, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                pop = 0;
                repeat (3000) @(negedge i_clk);
                rx_hold_req = 0;
            end
            pop = rx_steady || ($urandom_range(99) >= 6);
        end
    end

    // One input transaction; returns at a falling edge with push still high.
    task automatic send_item(logic [15:0] cx, cy, bw, bh, score, bit lc, bit la);
        if (!tx_steady && $urandom_range(99) < 6) begin
            push = 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        push = 1;
        i_center_x = cx; i_center_y = cy; i_box_width = bw; i_box_height = bh;
        i_class_score = score; i_last_class = lc; i_last_anchor = la;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Stop offering and let every expected result come out, then settle.
    task automatic drain();
        push = 0;
        while (waiting != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 0;
        case (idx)
            CFG_CONF_THR: cur_conf = data;
            CFG_DST_W:    cur_dst_w = data[11:0];
            CFG_DST_H:    cur_dst_h = data[11:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [15:0] conf, iou, logic [11:0] sw, sh, dw, dh);
        write_reg(CFG_CONF_THR, conf);
        write_reg(CFG_IOU_THR, iou);
        write_reg(CFG_SRC_W, sw);
        write_reg(CFG_SRC_H, sh);
        write_reg(CFG_DST_W, dw);
        write_reg(CFG_DST_H, dh);
    endtask

    // One anchor of ncls scores; the winning score sits at win_pos.
    // With drop_lc on a frame end, last_class stays low on the final item.
    task automatic send_anchor(logic [15:0] cx, cy, bw, bh, int ncls, int win_pos,
                               logic [15:0] win_score, bit frame_end, bit drop_lc);
        logic [15:0] s;
        int k;
        for (k = 0; k < ncls; k++) begin
            if (k == win_pos) s = win_score;
            else if ($urandom_range(9) == 0) s = win_score;          // tie, first wins
            else s = $urandom_range(win_score);
            send_item(cx, cy, bw, bh, s, (k == ncls - 1) && !(frame_end && drop_lc),
                      (k == ncls - 1) && frame_end);
        end
    endtask

    // A frame of random anchors clustered around a few spots so NMS has work.
    task automatic random_frame(int n_anchors, int pass_pct);
        logic [15:0] hx[3], hy[3], cx, cy, bw, bh, ws;
        int a, spot, ncls, span_x, span_y;
        span_x = (cur_dst_w == 0 ? 1 : cur_dst_w) * 16;
        span_y = (cur_dst_h == 0 ? 1 : cur_dst_h) * 16;
        for (a = 0; a < 3; a++) begin
            hx[a] = $urandom_range(span_x);
            hy[a] = $urandom_range(span_y);
        end
        for (a = 0; a < n_anchors; a++) begin
            if ($urandom_range(9) == 0) begin
                cx = $urandom; cy = $urandom; bw = $urandom; bh = $urandom;
            end else begin
                spot = $urandom_range(2);
                cx = hx[spot] + $urandom_range(128) - 64;
                cy = hy[spot] + $urandom_range(128) - 64;
                bw = $urandom_range(span_x / 3 + 16);
                bh = $urandom_range(span_y / 3 + 16);
            end
            ncls = ($urandom_range(29) == 0) ? $urandom_range(79, 84) : $urandom_range(1, 4);
            if ($urandom_range(99) < pass_pct && cur_conf != 16'hFFFF)
                ws = $urandom_range(16'hFFFF, cur_conf + 1);
            else
                ws = $urandom_range(cur_conf);
            send_anchor(cx, cy, bw, bh, ncls, $urandom_range(ncls - 1), ws,
                        a == n_anchors - 1, $urandom_range(7) == 0);
        end
        frames_sent++;
    endtask

    initial begin
        int phase;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: reset settings first.
        // Largest box fields clamp at the far edge.
        send_anchor(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 16'hFFFF, 1, 0);
        // Score equal to the threshold is rejected, one above passes; zero box at origin;
        // frame closed by last_anchor alone.
        send_anchor(16'd0, 16'd0, 16'd0, 16'd0, 1, 0, 16'd16384, 0, 0);
        send_anchor(16'd0, 16'd0, 16'd0, 16'd0, 1, 0, 16'd16385, 1, 1);
        // Empty frame.
        send_item(16'd5000, 16'd5000, 16'd800, 16'd800, 16'd0, 1, 1);
        // Identical boxes: equal scores tie to the earlier one and suppress; other class kept.
        send_item(16'd4000, 16'd4000, 16'd1600, 16'd1600, 16'd50000, 1, 0);
        send_item(16'd4000, 16'd4000, 16'd1600, 16'd1600, 16'd50000, 1, 0);
        send_item(16'd4000, 16'd4000, 16'd1600, 16'd1600, 16'd100, 0, 0);
        send_item(16'd4000, 16'd4000, 16'd1600, 16'd1600, 16'd50000, 1, 1);
        drain();
        // Scores past the class limit are ignored by the argmax.
        send_anchor(16'd3000, 16'd3000, 16'd900, 16'd900, 81, 80, 16'hFFFF, 1, 0);
        drain();

        // Random phases over several settings, extremes included.
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: load_settings(16'd16384, 16'd29491, 12'd640, 12'd480, 12'd640, 12'd640);
                1: load_settings(16'd0, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0);
                2: load_settings(16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
                3: load_settings(16'd100, 16'hFFFF, 12'd1920, 12'd1080, 12'd640, 12'd640);
                4: load_settings(16'd30000, 16'd20000, 12'd1, 12'hFFF, 12'hFFF, 12'd1);
                5: load_settings($urandom, $urandom, $urandom_range(4095, 1),
                                 $urandom_range(4095, 1), $urandom_range(4095, 1),
                                 $urandom_range(4095, 1));
                default: load_settings(16'd16384, 16'd29491, 12'd640, 12'd480,
                                       12'd640, 12'd640);
            endcase
            if (phase == 3) begin
                // Table overflow, sent without idling.
                tx_steady = 1;
                rx_steady = 1;
                random_frame(70, 100);
                tx_steady = 0;
                rx_steady = 0;
            end
            if (phase == 5) begin
                // Receiver holds off while two frames follow back to back: full must rise.
                rx_hold_req = 1;
                random_frame(3, 80);
                random_frame(12, 100);
            end
            while (items_sent < 60 * (phase + 1) + 80)
                random_frame($urandom_range(1, 8), 60);
            drain();
        end

        drain();
        $display("Run: %0d score items in %0d random frames, %0d results checked, %0d overflow frames",
                 items_sent, frames_sent, results_seen, overflow_frames);
        $display("Settings swept: threshold and size extremes, zero sizes, class limit, ties");
        if (fail_count == 0 && waiting == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
